// ===== rtl/tkms_pkg.sv =====
// ----------------------------------------------------------------------------
// tkms_pkg
// shared types and constants of the top-k segment sum core
// ----------------------------------------------------------------------------
package tkms_pkg;

  localparam int unsigned SumW = 32;
  localparam int unsigned PosW = 11;
  localparam int unsigned ScoreW = 16;
  localparam int unsigned KW = 4;
  localparam int unsigned SeqLenMax = 1024;

  localparam logic [0:0] CfgTopCount = 1'b0;
  localparam logic [0:0] CfgChannelMode = 1'b1;

  localparam logic signed [SumW-1:0] SumMax = 32'sh7fffffff;
  localparam logic signed [SumW-1:0] SumMin = 32'sh80000000;

  typedef logic signed [SumW-1:0] sum_t;

  // adder operation of the shared arithmetic unit
  typedef enum logic [1:0] {
    OpAdd = 2'd0,
    OpSub = 2'd1
  } alu_op_e;

  function automatic sum_t sat_add(input sum_t a, input sum_t b, input alu_op_e op);
    logic signed [SumW:0] r;
    r = (op == OpSub) ? ({a[SumW-1], a} - {b[SumW-1], b}) : ({a[SumW-1], a} + {b[SumW-1], b});
    if (r > $signed({1'b0, SumMax})) return SumMax;
    if (r < $signed({1'b1, SumMin})) return SumMin;
    return r[SumW-1:0];
  endfunction

endpackage

// ===== rtl/top_k_max_segment_sums_core.sv =====
// ----------------------------------------------------------------------------
// top_k_max_segment_sums_core
// keeps the k best segment sums of a score sequence; a last step emits them up to tlast
// ----------------------------------------------------------------------------
// channel   dir  handshake          payload
// s_axis    in   tvalid/tready      tdata {c,b,a}, tuser {last,first}
// m_axis    out  tvalid/tready      tdata {found,end,start,sum,rank}, tlast
// cfg       in   cfg_valid/ready    cfg_index, cfg_wdata
//
// a transaction runs prefix update, candidate merge and anchor scan in plain mode,
// and candidate merge, middle score update of the anchors and anchor scan in
// structured mode; merge and update go through the single saturating adder, the
// scan compares directly. the opening structured step only loads anchor 0. a
// last step then emits k list entries. output is registered; a stalled sink
// holds the emission. reset clears the valid flags, prefix and anchors; no clearing pass is needed.
// ----------------------------------------------------------------------------
module top_k_max_segment_sums_core #(
  parameter int unsigned MAX_K = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // score_a, score_b, score_c
  input  logic [1:0]  s_axis_tuser,   // first, last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // rank, sum, seg_start, seg_end, found
  output logic        m_axis_tlast,   // final_res
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [3:0]  cfg_wdata
);
  import tkms_pkg::*;

  localparam int unsigned IW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int unsigned CW = $clog2(MAX_K + 1);

  typedef enum logic [2:0] {
    StIdle, StPrefix, StCand, StAnchorScan, StAnchorAdd, StEmit
  } state_e;

  state_e state_q;
  logic [KW-1:0] top_count_q;
  logic mode_q;
  sum_t prefix_q;
  logic [PosW-1:0] stepn_q, jpos_q;
  sum_t av_q [MAX_K];
  logic [PosW-1:0] ap_q [MAX_K];
  logic [MAX_K-1:0] avld_q;
  sum_t bs_q [MAX_K];
  logic [PosW-1:0] bst_q [MAX_K];
  logic [PosW-1:0] ben_q [MAX_K];
  logic [MAX_K-1:0] bvld_q;
  logic [CW-1:0] l_q, p_q, k_q;
  logic last_q;
  sum_t a_q, b_q, c_q;
  logic anchor_done_q;

  // shared alu
  sum_t alu_x, alu_y, alu_r;
  alu_op_e alu_op;
  assign alu_r = sat_add(alu_x, alu_y, alu_op);

  logic [IW-1:0] li, pi;
  assign li = l_q[IW-1:0];
  assign pi = p_q[IW-1:0];

  always_comb begin
    alu_x = prefix_q;
    alu_y = a_q;
    alu_op = OpAdd;
    unique case (state_q)
      StPrefix: begin alu_x = prefix_q; alu_y = a_q; alu_op = OpAdd; end
      StCand: begin
        if (mode_q) begin alu_x = av_q[li]; alu_y = c_q; alu_op = OpAdd; end
        else begin alu_x = prefix_q; alu_y = av_q[li]; alu_op = OpSub; end
      end
      StAnchorAdd: begin alu_x = av_q[li]; alu_y = b_q; alu_op = OpAdd; end
      default: ;
    endcase
  end

  logic [KW-1:0] kraw;
  logic [CW-1:0] kact;
  always_comb begin
    kraw = cfg_wdata;
    if (top_count_q == '0) kact = CW'(1);
    else if (32'(top_count_q) > MAX_K) kact = CW'(MAX_K);
    else kact = CW'(top_count_q);
  end

  assign s_axis_tready = (state_q == StIdle);
  assign cfg_ready = 1'b1;
  logic in_fire;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  // output register
  logic [2:0] o_rank_q;
  sum_t o_sum_q;
  logic [PosW-1:0] o_st_q, o_en_q;
  logic o_fnd_q, o_last_q, o_vld_q;
  assign m_axis_tvalid = o_vld_q;
  assign m_axis_tdata = {6'd0, o_fnd_q, o_en_q, o_st_q, o_sum_q, o_rank_q};
  assign m_axis_tlast = o_last_q;

  // next list entry goes into the output register
  logic emit_go;
  assign emit_go = (state_q == StEmit) && anchor_done_q && (!o_vld_q || m_axis_tready);

  // candidate insertion position helper
  logic cand_le;
  assign cand_le = bvld_q[pi] && (alu_r <= bs_q[pi]);
  logic put_here;
  logic [PosW-1:0] cand_st;
  assign cand_st = mode_q ? ap_q[li] : ap_q[li] + PosW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      top_count_q <= KW'(8);
      mode_q <= 1'b0;
      prefix_q <= '0;
      stepn_q <= '0;
      avld_q <= MAX_K'(1);
      bvld_q <= '0;
      o_vld_q <= 1'b0;
      for (int i = 0; i < MAX_K; i++) begin
        av_q[i] <= '0;
        ap_q[i] <= '0;
      end
      l_q <= '0; p_q <= '0; k_q <= '0; last_q <= 1'b0;
      anchor_done_q <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CfgTopCount) top_count_q <= kraw;
        else mode_q <= kraw[0];
      end
      if (emit_go) o_vld_q <= 1'b1;
      else if (m_axis_tready) o_vld_q <= 1'b0;
      unique case (state_q)
        StIdle: if (in_fire) begin
          a_q <= {{(SumW-ScoreW){s_axis_tdata[15]}}, s_axis_tdata[15:0]};
          b_q <= {{(SumW-ScoreW){s_axis_tdata[31]}}, s_axis_tdata[31:16]};
          c_q <= {{(SumW-ScoreW){s_axis_tdata[47]}}, s_axis_tdata[47:32]};
          last_q <= s_axis_tuser[1];
          k_q <= kact;
          l_q <= '0; p_q <= '0;
          anchor_done_q <= 1'b0;
          if (s_axis_tuser[0]) begin
            prefix_q <= '0; stepn_q <= '0; bvld_q <= '0;
            for (int i = 1; i < MAX_K; i++) begin av_q[i] <= '0; ap_q[i] <= '0; end
            jpos_q <= mode_q ? PosW'(0) : PosW'(1);
          end else if (mode_q) jpos_q <= stepn_q;
          else jpos_q <= (32'(stepn_q) + 1 > SeqLenMax) ? PosW'(SeqLenMax)
                                                        : stepn_q + PosW'(1);
          if (s_axis_tuser[0] || (mode_q && stepn_q == '0)) begin
            avld_q <= MAX_K'(1);
            ap_q[0] <= '0;
          end
          if (mode_q && (s_axis_tuser[0] || stepn_q == '0)) begin
            // first structured step: load anchor 0 only
            av_q[0] <= {{(SumW-ScoreW){s_axis_tdata[15]}}, s_axis_tdata[15:0]};
            state_q <= StEmit;
          end else begin
            if (s_axis_tuser[0]) av_q[0] <= '0;
            state_q <= mode_q ? StCand : StPrefix;
          end
        end
        StPrefix: begin
          prefix_q <= alu_r;
          state_q <= StCand;
        end
        StCand: begin
          // p advances while list entry >= cand; then the candidate is inserted and l moves on
          if (l_q >= k_q || !avld_q[li] || p_q >= k_q) begin
            l_q <= '0;
            state_q <= mode_q ? StAnchorAdd : StAnchorScan;
          end else if (cand_le) p_q <= p_q + CW'(1);
          else begin
            for (int q = MAX_K - 1; q > 0; q--)
              if (q < k_q && q > p_q) begin
                bs_q[q] <= bs_q[q-1]; bst_q[q] <= bst_q[q-1];
                ben_q[q] <= ben_q[q-1]; bvld_q[q] <= bvld_q[q-1];
              end
            bs_q[pi] <= alu_r; bst_q[pi] <= cand_st; ben_q[pi] <= jpos_q;
            bvld_q[pi] <= 1'b1;
            l_q <= l_q + CW'(1);
          end
        end
        StAnchorAdd: begin
          if (l_q >= k_q || !avld_q[li]) begin
            l_q <= '0; state_q <= StAnchorScan;
          end else begin
            av_q[li] <= alu_r; l_q <= l_q + CW'(1);
          end
        end
        StAnchorScan: begin
          if (l_q >= k_q) begin
            state_q <= StEmit; l_q <= '0;
          end else if (put_here) begin
            for (int n = MAX_K - 1; n > 0; n--)
              if (n < k_q && n > l_q) begin
                av_q[n] <= av_q[n-1]; ap_q[n] <= ap_q[n-1]; avld_q[n] <= avld_q[n-1];
              end
            av_q[li] <= mode_q ? a_q : prefix_q;
            ap_q[li] <= jpos_q; avld_q[li] <= 1'b1;
            state_q <= StEmit; l_q <= '0;
          end else l_q <= l_q + CW'(1);
        end
        StEmit: begin
          if (!anchor_done_q) begin
            anchor_done_q <= 1'b1;
            if (32'(stepn_q) < SeqLenMax) stepn_q <= stepn_q + PosW'(1);
            l_q <= '0;
            if (!last_q) state_q <= StIdle;
          end else if (emit_go) begin
            o_rank_q <= 3'(l_q);
            o_fnd_q <= bvld_q[li];
            o_sum_q <= bvld_q[li] ? bs_q[li] : '0;
            o_st_q <= bvld_q[li] ? bst_q[li] : '0;
            o_en_q <= bvld_q[li] ? ben_q[li] : '0;
            o_last_q <= (l_q == k_q - CW'(1));
            if (l_q == k_q - CW'(1)) state_q <= StIdle;
            else l_q <= l_q + CW'(1);
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_comb begin
    put_here = !avld_q[li] || (mode_q ? (a_q > av_q[li]) : (prefix_q < av_q[li]));
  end

  ap_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> state_q == StIdle) else $error("ready outside idle");
  ap_k_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != StIdle |-> (k_q >= CW'(1) && 32'(k_q) <= MAX_K)) else $error("k range");
  ap_anchor0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StIdle |-> avld_q[0]) else $error("anchor 0 lost");
  ap_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_vld_q && !m_axis_tready) |=> $stable(o_sum_q)) else $error("output changed");

endmodule

// ===== bench/tkms_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tkms_checker
// watches the score, result and register channels of the top-k segment sum
// core, predicts the emitted lists and compares them field by field
// ----------------------------------------------------------------------------
module tkms_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [63:0] m_axis_tdata,
  input  logic        m_axis_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [3:0]  cfg_wdata,
  output int          errors_o,
  output int          pending_o
);
  import tkms_pkg::*;

  localparam int Kmax = 8;
  localparam int SeqMax = 1024;

  typedef struct {
    logic [2:0]      rank;
    logic [31:0]     sum;
    logic [PosW-1:0] seg_start;
    logic [PosW-1:0] seg_end;
    logic            found;
    logic            final_res;
  } entry_t;

  entry_t entries_q[$];

  logic [3:0] k_reg;
  logic       structured;
  longint     run_total;
  int         run_pos;
  longint     open_val[Kmax];
  int         open_pos[Kmax];
  bit         open_ok[Kmax];
  longint     list_sum[Kmax];
  int         list_start[Kmax];
  int         list_end[Kmax];
  bit         list_ok[Kmax];
  int         err_count = 0;
  int         pend_count = 0;

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic void restart_run();
    run_total = 0;
    run_pos = 0;
    for (int i = 0; i < Kmax; i++) begin
      open_val[i] = 0;
      open_pos[i] = 0;
      open_ok[i] = (i == 0);
      list_ok[i] = 0;
    end
  endfunction

  // candidate goes behind every entry that is greater or equal
  function automatic bit insert_best(int k, inout int p, input longint cand, input int st,
                                     input int en);
    while (p < k && list_ok[p] && cand <= list_sum[p]) p++;
    if (p >= k) return 0;
    for (int q = k - 1; q > p; q--) begin
      list_sum[q] = list_sum[q-1];
      list_start[q] = list_start[q-1];
      list_end[q] = list_end[q-1];
      list_ok[q] = list_ok[q-1];
    end
    list_sum[p] = cand;
    list_start[p] = st & 'h7ff;
    list_end[p] = en & 'h7ff;
    list_ok[p] = 1;
    return 1;
  endfunction

  function automatic void place_opening(int k, int l, longint v, int pos);
    for (int n = k - 1; n > l; n--) begin
      open_val[n] = open_val[n-1];
      open_pos[n] = open_pos[n-1];
      open_ok[n] = open_ok[n-1];
    end
    open_val[l] = v;
    open_pos[l] = pos;
    open_ok[l] = 1;
  endfunction

  function automatic void predict_step(logic [47:0] data, logic [1:0] flags);
    int     k, j, p;
    longint a, b, c;
    entry_t e;
    k = (k_reg == 0) ? 1 : (k_reg > Kmax) ? Kmax : int'(k_reg);
    a = longint'($signed(data[15:0]));
    b = longint'($signed(data[31:16]));
    c = longint'($signed(data[47:32]));
    p = 0;
    if (flags[0]) restart_run();
    if (!structured) begin
      j = (run_pos + 1 > SeqMax) ? SeqMax : run_pos + 1;
      run_total = clip32(run_total + a);
      for (int l = 0; l < k; l++) begin
        if (!open_ok[l]) break;
        if (!insert_best(k, p, clip32(run_total - open_val[l]), open_pos[l] + 1, j)) break;
      end
      for (int l = 0; l < k; l++) begin
        if (!open_ok[l] || run_total < open_val[l]) begin
          place_opening(k, l, run_total, j);
          break;
        end
      end
    end else if (run_pos == 0) begin
      // opening step only loads the start score
      for (int l = 0; l < Kmax; l++) open_ok[l] = 0;
      open_val[0] = a;
      open_pos[0] = 0;
      open_ok[0] = 1;
    end else begin
      j = (run_pos > SeqMax) ? SeqMax : run_pos;
      for (int l = 0; l < k; l++) begin
        if (!open_ok[l]) break;
        if (!insert_best(k, p, clip32(open_val[l] + c), open_pos[l], j)) break;
      end
      for (int l = 0; l < k; l++) begin
        if (!open_ok[l]) break;
        open_val[l] = clip32(open_val[l] + b);
      end
      for (int l = 0; l < k; l++) begin
        if (!open_ok[l] || a > open_val[l]) begin
          place_opening(k, l, a, j);
          break;
        end
      end
    end
    if (run_pos < SeqMax) run_pos++;
    if (flags[1]) begin
      for (int i = 0; i < k; i++) begin
        e.rank = i[2:0];
        e.sum = list_ok[i] ? list_sum[i][31:0] : '0;
        e.seg_start = list_ok[i] ? list_start[i][PosW-1:0] : '0;
        e.seg_end = list_ok[i] ? list_end[i][PosW-1:0] : '0;
        e.found = list_ok[i];
        e.final_res = (i == k - 1);
        entries_q.push_back(e);
      end
    end
  endfunction

  assign errors_o = err_count;
  assign pending_o = pend_count;

  always @(posedge clk_i) begin
    entry_t want;
    if (!rst_ni) begin
      k_reg = 4'd8;
      structured = 1'b0;
      restart_run();
      entries_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CfgTopCount) k_reg = cfg_wdata;
        else structured = cfg_wdata[0];
      end
      if (s_axis_tvalid && s_axis_tready) predict_step(s_axis_tdata, s_axis_tuser);
      if (m_axis_tvalid && m_axis_tready) begin
        if (entries_q.size() == 0) begin
          $error("result transaction with nothing expected: tdata %h", m_axis_tdata);
          err_count++;
        end else begin
          want = entries_q.pop_front();
          if (m_axis_tdata[2:0] !== want.rank) begin
            $error("rank: expected %0d, got %0d", want.rank, m_axis_tdata[2:0]);
            err_count++;
          end
          if (m_axis_tdata[34:3] !== want.sum) begin
            $error("sum: expected %0d, got %0d", $signed(want.sum),
                   $signed(m_axis_tdata[34:3]));
            err_count++;
          end
          if (m_axis_tdata[45:35] !== want.seg_start) begin
            $error("seg_start: expected %0d, got %0d", want.seg_start, m_axis_tdata[45:35]);
            err_count++;
          end
          if (m_axis_tdata[56:46] !== want.seg_end) begin
            $error("seg_end: expected %0d, got %0d", want.seg_end, m_axis_tdata[56:46]);
            err_count++;
          end
          if (m_axis_tdata[57] !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, m_axis_tdata[57]);
            err_count++;
          end
          if (m_axis_tlast !== want.final_res) begin
            $error("final_res: expected %0d, got %0d", want.final_res, m_axis_tlast);
            err_count++;
          end
        end
      end
    end
    pend_count = entries_q.size();
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// score stimulus for the top-k segment sum core in both modes and several
// list sizes, with random stalls on both channels; verdict from the checker
// ----------------------------------------------------------------------------
module testbench;
  import tkms_pkg::*;

  localparam int CycleLimit = 3000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic        m_tlast;
  logic        c_valid = 1'b0;
  logic        c_ready;
  logic [0:0]  c_index = CfgTopCount;
  logic [3:0]  c_wdata = '0;
  int          errors;
  int          pending;
  int          cycles = 0;
  bit          calm = 0;
  bit          hold_go = 0;

  always #1 clk_i = ~clk_i;

  top_k_max_segment_sums_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready),
    .s_axis_tdata(s_tdata), .s_axis_tuser(s_tuser),
    .m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready),
    .m_axis_tdata(m_tdata), .m_axis_tlast(m_tlast),
    .cfg_valid(c_valid), .cfg_ready(c_ready),
    .cfg_index(c_index), .cfg_wdata(c_wdata)
  );

  tkms_checker chk (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready),
    .s_axis_tdata(s_tdata), .s_axis_tuser(s_tuser),
    .m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready),
    .m_axis_tdata(m_tdata), .m_axis_tlast(m_tlast),
    .cfg_valid(c_valid), .cfg_ready(c_ready),
    .cfg_index(c_index), .cfg_wdata(c_wdata),
    .errors_o(errors), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // result side: random ready bursts, long hold-off on request
  initial begin
    int  run_left;
    int  hold_left;
    bit  rdy;
    bit  hold_seen;
    run_left = 0;
    hold_left = 0;
    rdy = 1;
    hold_seen = 0;
    forever begin
      @(posedge clk_i);
      if (hold_go && !hold_seen) begin
        hold_seen = 1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (calm) begin
        m_tready <= 1'b1;
      end else begin
        if (run_left == 0) begin
          rdy = ($urandom_range(0, 2) != 0);
          run_left = $urandom_range(1, 19);
        end
        run_left--;
        m_tready <= rdy;
      end
    end
  end

  task automatic send_step(bit first, bit last, logic [15:0] a, logic [15:0] b,
                           logic [15:0] c);
    int gap;
    gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 19) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {c, b, a};
    s_tuser <= {last, first};
    do @(posedge clk_i); while (!s_tready);
  endtask

  // wait for every list entry, then for the core to finish any silent step
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [3:0] val);
    drain();
    c_valid <= 1'b1;
    c_index <= idx;
    c_wdata <= val;
    do @(posedge clk_i); while (!c_ready);
    c_valid <= 1'b0;
  endtask

  function automatic logic [15:0] pick_score();
    case ($urandom_range(0, 4))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'($signed($urandom_range(0, 1024)) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_runs(int n);
    int left, len, i;
    bit noisy;
    left = n;
    while (left > 0) begin
      len = $urandom_range(1, 8);
      noisy = ($urandom_range(0, 9) == 0);
      for (i = 0; i < len && left > 0; i++) begin
        send_step(noisy ? 1'($urandom) : (i == 0),
                  noisy ? 1'($urandom) : (i == len - 1),
                  pick_score(), pick_score(), pick_score());
        left--;
      end
      if ($urandom_range(0, 7) == 0) drain();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset state acts as run start, no first marker
    send_step(0, 1, 16'h0100, 16'h0, 16'h0);
    send_step(1, 0, 16'h7fff, 16'h0, 16'h0);
    send_step(0, 0, 16'h8000, 16'h0, 16'h0);
    send_step(0, 0, 16'hffff, 16'h0, 16'h0);
    send_step(0, 1, 16'h0000, 16'h0, 16'h0);
    // continuing after last without first
    send_step(0, 1, 16'h0200, 16'h0, 16'h0);
    // ties between equal sums
    send_step(1, 0, 16'h0100, 16'h0, 16'h0);
    send_step(0, 0, 16'hff00, 16'h0, 16'h0);
    send_step(0, 1, 16'h0100, 16'h0, 16'h0);
    // mode change in a running run
    send_step(1, 0, 16'h0300, 16'h0, 16'h0);
    write_reg(CfgChannelMode, 4'd1);
    send_step(0, 1, 16'h0100, 16'h0200, 16'h0300);
    // structured: opening step alone, then extremes
    send_step(1, 1, 16'h7fff, 16'h7fff, 16'h7fff);
    send_step(1, 0, 16'h8000, 16'h8000, 16'h8000);
    send_step(0, 0, 16'h7fff, 16'h8000, 16'h7fff);
    send_step(0, 0, 16'h5555, 16'haaaa, 16'h5555);
    send_step(0, 1, 16'haaaa, 16'h5555, 16'haaaa);
    write_reg(CfgTopCount, 4'd0);
    send_step(1, 0, 16'h0010, 16'h0020, 16'h0030);
    send_step(0, 1, 16'h0040, 16'h0001, 16'h0050);

    write_reg(CfgChannelMode, 4'd0);
    write_reg(CfgTopCount, 4'd8);
    hold_go = 1;
    random_runs(26);
    drain();
    write_reg(CfgTopCount, 4'd3);
    write_reg(CfgChannelMode, 4'd1);
    random_runs(26);
    write_reg(CfgTopCount, 4'd15);
    random_runs(26);
    write_reg(CfgChannelMode, 4'd0);
    write_reg(CfgTopCount, 4'd1);
    random_runs(20);

    // steady run of full scale scores, back to back
    calm = 1;
    write_reg(CfgTopCount, 4'd2);
    send_step(1, 0, 16'h8000, 16'h0, 16'h0);
    for (int i = 0; i < 6; i++) send_step(0, 0, 16'h7fff, 16'h0, 16'h0);
    send_step(0, 1, 16'h7fff, 16'h0, 16'h0);
    write_reg(CfgTopCount, 4'd8);
    random_runs(10);
    s_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/tkms_pkg.sv
rtl/top_k_max_segment_sums_core.sv
bench/tkms_checker.sv
bench/testbench.sv
